[design/gcnl_pkg.sv]
// Package for the grid cell neighbor list unit.
// Holds field widths, reset constants and the queue entry type.
// Used by every module of the block; depends on nothing.
`default_nettype none

package gcnl_pkg;

  // Width of a linear cell index, as carried on both channels.
  localparam int unsigned REGION_W = 18;
  // Padded stream data width (whole bytes).
  localparam int unsigned TDATA_W = 24;
  // Width of the grid side register and its reset value.
  localparam int unsigned SIDE_W = 7;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd8;

  // One decoded item handed from the front to the back. All address
  // arithmetic is modulo 2**REGION_W, which matches the masked result.
  typedef struct packed {
    logic [REGION_W-1:0] start_addr; // first neighbor in walk order
    logic [REGION_W-1:0] step_k;     // delta for the next k
    logic [REGION_W-1:0] step_j;     // delta when k wraps and j advances
    logic [REGION_W-1:0] step_i;     // delta when j and k wrap and i advances
    logic [1:0]          span_i;     // number of i positions minus one
    logic [1:0]          span_j;
    logic [1:0]          span_k;
    logic                err;        // index not below side cubed
  } qent_t;

endpackage : gcnl_pkg

`default_nettype wire

[design/gcnl_front.sv]
// Front part of the grid cell neighbor list unit: input buffer, range
// check and an iterative divider that recovers i, j and k of the cell.
// Depends on gcnl_pkg.
`default_nettype none

module gcnl_front #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [gcnl_pkg::REGION_W-1:0]      in_idx,
  input  wire logic [$clog2(MAX_SIDE+1)-1:0]      side,
  output logic                                    push_valid,
  input  wire logic                               push_ready,
  output gcnl_pkg::qent_t                         push_data
);

  localparam int unsigned RW   = gcnl_pkg::REGION_W;
  localparam int unsigned SW   = $clog2(MAX_SIDE + 1);
  localparam int unsigned QW   = $clog2(MAX_SIDE);
  localparam int unsigned PW   = 2 * SW;
  localparam int unsigned CW   = 3 * SW;
  localparam int unsigned DVW  = PW + QW;
  localparam int unsigned CMPW = (RW > DVW) ? RW : DVW;
  localparam int unsigned XW   = (RW > CW) ? RW : CW;
  localparam int unsigned CNTW = (QW > 1) ? $clog2(QW) : 1;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_SQ   = 6'b000010,
    F_CUBE = 6'b000100,
    F_CHK  = 6'b001000,
    F_DIV  = 6'b010000,
    F_PUSH = 6'b100000
  } fstate_t;

  fstate_t              state_r, state_nxt;
  logic                 buf_valid_r;
  logic [RW-1:0]        buf_idx_r;
  logic [RW-1:0]        idx_r;
  logic [SW-1:0]        n_r;
  logic [PW-1:0]        nsq_r;
  logic [CW-1:0]        cube_r;
  logic [RW-1:0]        rem_r, rem_nxt;
  logic [DVW-1:0]       dvs_r;
  logic [QW-1:0]        q_r, q_nxt;
  logic [QW-1:0]        k_r;
  logic [QW-1:0]        j_r;
  logic [CNTW-1:0]      cnt_r;
  logic                 phase_r;
  logic                 err_r;
  logic                 ge;

  // Input buffer: one item waits here while the divider is busy.
  assign in_tready = !buf_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      buf_valid_r <= 1'b1;
    end else if (state_r == F_IDLE) begin
      buf_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      buf_idx_r <= in_idx;
    end
  end

  // One restoring division step on the current remainder.
  assign ge      = CMPW'(rem_r) >= CMPW'(dvs_r);
  assign rem_nxt = ge ? RW'(CMPW'(rem_r) - CMPW'(dvs_r)) : rem_r;
  assign q_nxt   = QW'({q_r, ge});

  // Sequencer state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (buf_valid_r) state_nxt = F_SQ;
      F_SQ:   state_nxt = F_CUBE;
      F_CUBE: state_nxt = F_CHK;
      F_CHK:  state_nxt = (XW'(idx_r) >= XW'(cube_r)) ? F_PUSH : F_DIV;
      F_DIV:  if (cnt_r == CNTW'(QW - 1) && phase_r) state_nxt = F_PUSH;
      F_PUSH: if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: square, cube, range check, then k and j by division.
  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        idx_r <= buf_idx_r;
        n_r   <= side;
      end
      F_SQ: begin
        nsq_r <= PW'(PW'(n_r) * PW'(n_r));
      end
      F_CUBE: begin
        cube_r <= CW'(CW'(nsq_r) * CW'(n_r));
      end
      F_CHK: begin
        err_r   <= XW'(idx_r) >= XW'(cube_r);
        rem_r   <= idx_r;
        dvs_r   <= DVW'(nsq_r) << (QW - 1);
        q_r     <= '0;
        cnt_r   <= '0;
        phase_r <= 1'b0;
      end
      F_DIV: begin
        rem_r <= rem_nxt;
        if (cnt_r == CNTW'(QW - 1)) begin
          cnt_r <= '0;
          q_r   <= '0;
          dvs_r <= DVW'(n_r) << (QW - 1);
          if (!phase_r) begin
            k_r     <= q_nxt;
            phase_r <= 1'b1;
          end else begin
            j_r <= q_nxt;
          end
        end else begin
          cnt_r <= cnt_r + CNTW'(1);
          q_r   <= q_nxt;
          dvs_r <= dvs_r >> 1;
        end
      end
      default: begin
      end
    endcase
  end

  // Walk bounds and address deltas for the back part.
  logic          i_lo, i_hi, j_lo, j_hi, k_lo, k_hi;
  logic [1:0]    si, sj, sk;
  logic [RW-1:0] n18, nsq18, skn, sjn;

  assign n18   = RW'(n_r);
  assign nsq18 = RW'(nsq_r);
  assign i_lo  = rem_r != '0;
  assign i_hi  = (RW + 1)'(rem_r) + (RW + 1)'(1) < (RW + 1)'(n_r);
  assign j_lo  = j_r != '0;
  assign j_hi  = (SW + 1)'(j_r) + (SW + 1)'(1) < (SW + 1)'(n_r);
  assign k_lo  = k_r != '0;
  assign k_hi  = (SW + 1)'(k_r) + (SW + 1)'(1) < (SW + 1)'(n_r);
  assign si    = {1'b0, i_lo} + {1'b0, i_hi};
  assign sj    = {1'b0, j_lo} + {1'b0, j_hi};
  assign sk    = {1'b0, k_lo} + {1'b0, k_hi};

  always_comb begin
    case (sk)
      2'd2:    skn = nsq18 << 1;
      2'd1:    skn = nsq18;
      default: skn = '0;
    endcase
    case (sj)
      2'd2:    sjn = n18 << 1;
      2'd1:    sjn = n18;
      default: sjn = '0;
    endcase
  end

  always_comb begin
    push_data = '0;
    if (err_r) begin
      push_data.err = 1'b1;
    end else begin
      push_data.start_addr = idx_r - RW'(i_lo) - (j_lo ? n18 : '0) - (k_lo ? nsq18 : '0);
      push_data.step_k     = nsq18;
      push_data.step_j     = n18 - skn;
      push_data.step_i     = RW'(1) - sjn - skn;
      push_data.span_i     = si;
      push_data.span_j     = sj;
      push_data.span_k     = sk;
    end
  end

  assign push_valid = state_r == F_PUSH;

endmodule : gcnl_front

`default_nettype wire

[design/gcnl_queue.sv]
// Two-entry queue between the front and back parts of the neighbor unit.
// Depends on gcnl_pkg for the entry type.
`default_nettype none

module gcnl_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire gcnl_pkg::qent_t push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output gcnl_pkg::qent_t      pop_data
);

  gcnl_pkg::qent_t ent_r [2];
  logic            wp_r;
  logic            rp_r;
  logic [1:0]      cnt_r;
  logic            do_push, do_pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_data   = ent_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue fill level out of range");

  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wp_r == rp_r))
    else $error("queue pointers disagree with fill level");

endmodule : gcnl_queue

`default_nettype wire

[design/gcnl_back.sv]
// Back part of the neighbor unit: walks the neighborhood of one queued
// item and, while out_ready is high, presents one neighbor index per cycle
// in an output register. Depends on gcnl_pkg.
`default_nettype none

module gcnl_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  output logic                                q_ready,
  input  wire gcnl_pkg::qent_t                q_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [gcnl_pkg::REGION_W-1:0]       out_addr,
  output logic                                out_last,
  output logic                                out_err
);

  localparam int unsigned RW = gcnl_pkg::REGION_W;

  logic          vld_r;
  logic [RW-1:0] addr_r, dk_r, dj_r, di_r;
  logic [1:0]    si_r, sj_r, sk_r;
  logic [1:0]    ca_r, cb_r, cc_r;
  logic          err_r;
  logic          last, take, pop;

  assign last = (ca_r == si_r) && (cb_r == sj_r) && (cc_r == sk_r);
  assign take = vld_r && out_ready;
  assign pop  = q_valid && (!vld_r || (take && last));

  assign q_ready   = !vld_r || (take && last);
  assign out_valid = vld_r;
  assign out_addr  = addr_r;
  assign out_last  = last;
  assign out_err   = err_r;

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (pop) begin
      vld_r <= 1'b1;
    end else if (take && last) begin
      vld_r <= 1'b0;
    end
  end

  // Walk: k innermost, then j, then i; each step adds a precomputed delta.
  always_ff @(posedge clk) begin
    if (pop) begin
      addr_r <= q_data.start_addr;
      dk_r   <= q_data.step_k;
      dj_r   <= q_data.step_j;
      di_r   <= q_data.step_i;
      si_r   <= q_data.span_i;
      sj_r   <= q_data.span_j;
      sk_r   <= q_data.span_k;
      err_r  <= q_data.err;
      ca_r   <= 2'd0;
      cb_r   <= 2'd0;
      cc_r   <= 2'd0;
    end else if (take && !last) begin
      if (cc_r != sk_r) begin
        cc_r   <= cc_r + 2'd1;
        addr_r <= addr_r + dk_r;
      end else if (cb_r != sj_r) begin
        cc_r   <= 2'd0;
        cb_r   <= cb_r + 2'd1;
        addr_r <= addr_r + dj_r;
      end else begin
        cc_r   <= 2'd0;
        cb_r   <= 2'd0;
        ca_r   <= ca_r + 2'd1;
        addr_r <= addr_r + di_r;
      end
    end
  end

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && err_r) |-> (last && addr_r == '0))
    else $error("error item must be a single zero result");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (ca_r <= si_r && cb_r <= sj_r && cc_r <= sk_r))
    else $error("walk counter beyond its span");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !out_ready) |=> (vld_r && $stable(addr_r) && $stable(cc_r)))
    else $error("stalled result changed");

endmodule : gcnl_back

`default_nettype wire

[design/grid_cell_neighbor_list_unit.sv]
// Top level of the grid cell neighbor list unit: side register, front,
// queue and back. Depends on gcnl_pkg, gcnl_front, gcnl_queue, gcnl_back.
//
//   channel  direction  handshake            payload
//   in_      slave      in_tvalid/in_tready  in_tdata[17:0] region_index
//   out_     master     out_tvalid/tready    tdata[17:0] neighbor_region,
//                                            tlast last, tuser index_error
//   cfg_     slave      cfg_valid/cfg_ready  cfg_data[6:0] grid_side
//
// The back part issues one result per cycle while out_tready is high; an
// item yields as many results as it has in-bounds neighbors: 8 to 27, or 1
// for a side of one or a bad index.
// The front divider overlaps with the back through a two-entry queue, so
// the front can decode a new item while the back still walks earlier ones.
// Reset is synchronous and active low; grid_side resets to 8.
// A stall on out_ holds the result register; the front keeps working
// until the queue fills, and in_ keeps taking one item into its buffer.
`default_nettype none

module grid_cell_neighbor_list_unit #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input items.
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [gcnl_pkg::TDATA_W-1:0]  in_tdata,   // [17:0] region_index
  // Result items.
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [gcnl_pkg::TDATA_W-1:0]       out_tdata,  // [17:0] neighbor_region
  output logic                               out_tlast,
  output logic                               out_tuser,  // [0] index_error
  // Configuration write.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [gcnl_pkg::SIDE_W-1:0]   cfg_data    // [6:0] grid_side
);

  localparam int unsigned RW = gcnl_pkg::REGION_W;
  localparam int unsigned SW = $clog2(MAX_SIDE + 1);

  logic [gcnl_pkg::SIDE_W-1:0] side_r;
  logic [SW-1:0]               side_eff;
  logic                        push_valid, push_ready;
  gcnl_pkg::qent_t             push_data;
  logic                        q_valid, q_ready;
  gcnl_pkg::qent_t             q_data;
  logic [RW-1:0]               out_addr;

  // Grid side register, saturated to the supported maximum.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= gcnl_pkg::SIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      side_r <= cfg_data;
    end
  end

  assign side_eff = (32'(side_r) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(side_r);

  gcnl_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_idx     (in_tdata[RW-1:0]),
    .side       (side_eff),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  gcnl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  gcnl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_addr  (out_addr),
    .out_last  (out_tlast),
    .out_err   (out_tuser)
  );

  assign out_tdata = gcnl_pkg::TDATA_W'(out_addr);

endmodule : grid_cell_neighbor_list_unit

`default_nettype wire

[tb/sv/tb_grid_cell_neighbor_list_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for grid_cell_neighbor_list_unit: sends cell indexes under a range
// of grid sides and checks every listed neighbor against a local 3x3x3 enumeration.
// Depends on gcnl_pkg and the design sources only.

module tb_grid_cell_neighbor_list_unit;

  localparam int unsigned REGION_W = gcnl_pkg::REGION_W;
  localparam int unsigned TDATA_W = gcnl_pkg::TDATA_W;
  localparam int unsigned SIDE_W = gcnl_pkg::SIDE_W;
  localparam logic [SIDE_W-1:0] SIDE_RESET = gcnl_pkg::SIDE_RESET;
  localparam int unsigned MAX_SIDE = 64;
  localparam int unsigned CLK_PERIOD = 20;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 21;
  localparam logic [REGION_W-1:0] REGION_MAX = '1;

  typedef enum logic {REQ_INDEX, REQ_DRAIN} req_kind_t;

  typedef struct {
    req_kind_t           kind;
    logic [REGION_W-1:0] region;
  } cell_req_t;

  typedef struct {
    logic [REGION_W-1:0] region;
    logic                last;
    logic                err;
  } neighbor_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [TDATA_W-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;
  logic                out_tlast;
  logic                out_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [SIDE_W-1:0]   cfg_data = '0;

  // Local copy of the grid side register.
  logic [SIDE_W-1:0]   side_model = SIDE_RESET;

  cell_req_t           cell_requests[$];
  neighbor_t           expected_neighbors[$];
  int unsigned         mismatch_count = 0;
  int unsigned         idle_cycles = 0;
  // The monitor flips this on each accepted input; the sender tracks its own copy.
  bit                  in_take_tgl = 1'b0;
  bit                  in_seen_tgl = 1'b0;
  bit                  hold_for_drain = 1'b0;
  int unsigned         burst_left = 1;
  int unsigned         gap_left = 0;
  logic [15:0]         ready_pattern = '1;
  int unsigned         pattern_left = 0;

  grid_cell_neighbor_list_unit #(
    .MAX_SIDE(MAX_SIDE)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin : clock_gen
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Sides above the supported maximum behave as the maximum.
  function automatic int effective_side(input logic [SIDE_W-1:0] side);
    return (side > MAX_SIDE) ? int'(MAX_SIDE) : int'(side);
  endfunction

  // Appends the neighbors of one center cell, in walk order, to the expected results.
  task automatic enumerate_neighbors(input logic [REGION_W-1:0] center);
    int n;
    int nsq;
    int ci;
    int cj;
    int ck;
    int rem;
    int i;
    int j;
    int k;
    logic [REGION_W-1:0] cells[$];
    n = effective_side(side_model);
    nsq = n * n;
    if (int'(center) >= nsq * n) begin
      // Index outside the grid: a single flagged result.
      expected_neighbors.push_back('{region: '0, last: 1'b1, err: 1'b1});
      return;
    end
    ck = int'(center) / nsq;
    rem = int'(center) - nsq * ck;
    cj = rem / n;
    ci = rem - n * cj;
    for (int a = -1; a <= 1; a++) begin
      i = ci + a;
      if (i < 0 || i >= n) continue;
      for (int b = -1; b <= 1; b++) begin
        j = cj + b;
        if (j < 0 || j >= n) continue;
        for (int c = -1; c <= 1; c++) begin
          k = ck + c;
          if (k < 0 || k >= n) continue;
          cells.push_back(REGION_W'(i + n * j + nsq * k));
        end
      end
    end
    foreach (cells[p]) begin
      expected_neighbors.push_back('{region: cells[p], last: (p == cells.size() - 1),
                                     err: 1'b0});
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic queue_index(input logic [REGION_W-1:0] region);
    cell_requests.push_back('{kind: REQ_INDEX, region: region});
  endtask

  // Blocks until every queued item is sent and every result has arrived.
  task automatic wait_until_drained();
    do @(posedge clk);
    while (cell_requests.size() != 0 || in_tvalid || hold_for_drain ||
           expected_neighbors.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the grid side while the block is idle.
  task automatic write_side(input logic [SIDE_W-1:0] side);
    wait_until_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= side;
    do @(posedge clk);
    while (!cfg_ready);
    side_model = side;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender: bursts of items with random gaps, plus drain points on request.
  always @(negedge clk) begin : sender
    logic               next_valid;
    logic [TDATA_W-1:0] next_data;
    cell_req_t          req;
    next_valid = in_tvalid;
    next_data = in_tdata;
    if (in_take_tgl != in_seen_tgl) next_valid = 1'b0;
    in_seen_tgl = in_take_tgl;
    if (rst_n && !next_valid) begin
      if (hold_for_drain) begin
        if (expected_neighbors.size() == 0) hold_for_drain = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (cell_requests.size() > 0) begin
        req = cell_requests.pop_front();
        if (req.kind == REQ_DRAIN) begin
          hold_for_drain = 1'b1;
        end else begin
          next_valid = 1'b1;
          next_data = TDATA_W'(req.region);
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
    in_tvalid <= next_valid;
    in_tdata <= next_data;
  end

  // Receiver: ready follows a rotating pattern that is replaced when its countdown runs out.
  always @(negedge clk) begin : receiver
    if (pattern_left == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern = '1;
        1: ready_pattern = 16'($urandom) | 16'h0001;
        2: ready_pattern = 16'h0101;
        default: ready_pattern = 16'hA5A5;
      endcase
      pattern_left = 64;
    end
    pattern_left--;
    out_tready <= ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
  end

  // Monitor: predicts on each accepted item and checks each accepted result.
  always @(posedge clk) begin : monitor
    neighbor_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        enumerate_neighbors(in_tdata[REGION_W-1:0]);
        in_take_tgl = !in_take_tgl;
      end
      if (out_tvalid && out_tready) begin
        if (expected_neighbors.size() == 0) begin
          report_mismatch($sformatf("unexpected result, neighbor 0x%0h",
                                    out_tdata[REGION_W-1:0]));
        end else begin
          want = expected_neighbors.pop_front();
          if (out_tdata[REGION_W-1:0] !== want.region)
            report_mismatch($sformatf("neighbor_region got 0x%0h, expected 0x%0h",
                                      out_tdata[REGION_W-1:0], want.region));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last got %b, expected %b for neighbor 0x%0h",
                                      out_tlast, want.last, want.region));
          if (out_tuser !== want.err)
            report_mismatch($sformatf("index_error got %b, expected %b",
                                      out_tuser, want.err));
        end
      end
    end
  end

  // Watchdog: ends the run when no channel has moved an item for too long.
  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [SIDE_W-1:0] side;
    int                cube;
    int unsigned       drain_at;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset side of 8: corners, edges, interior cells and out-of-range indexes.
    queue_index(18'd0);
    queue_index(18'd7);
    queue_index(18'd56);
    queue_index(18'd63);
    queue_index(18'd73);
    queue_index(18'd292);
    queue_index(18'd511);
    queue_index(18'd512);
    queue_index(REGION_MAX);
    queue_index(18'h15555);
    queue_index(18'h2AAAA);

    // Largest side: the whole index range is inside the grid.
    write_side(7'd64);
    queue_index(18'd0);
    queue_index(REGION_MAX);
    queue_index(18'h15555);
    queue_index(18'h2AAAA);
    queue_index(18'(32 + 64 * 32 + 4096 * 32));

    // A single-cell grid lists only the cell itself.
    write_side(7'd1);
    queue_index(18'd0);
    queue_index(18'd1);

    // Side of zero: every index is out of range.
    write_side(7'd0);
    queue_index(18'd0);

    // Side above the maximum saturates.
    write_side(7'd127);
    queue_index(REGION_MAX);
    queue_index(18'd0);

    write_side(7'd2);
    queue_index(18'd0);
    queue_index(18'd7);
    queue_index(18'd8);

    write_side(7'd3);
    queue_index(18'd13);

    // Random phases, each under a new side, with one drain point per phase.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 6)
        0: side = 7'd64;
        1: side = SIDE_W'($urandom_range(2, 16));
        2: side = SIDE_W'($urandom_range(17, 63));
        3: side = SIDE_W'($urandom_range(65, 127));
        4: side = SIDE_W'($urandom_range(1, 4));
        default: side = SIDE_RESET;
      endcase
      write_side(side);
      cube = effective_side(side) ** 3;
      drain_at = $urandom_range(1, ITEMS_PER_PHASE - 1);
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == drain_at) cell_requests.push_back('{kind: REQ_DRAIN, region: '0});
        if (cube > 0 && $urandom_range(0, 3) != 0)
          queue_index(REGION_W'($urandom_range(0, cube - 1)));
        else
          queue_index(REGION_W'($urandom_range(0, int'(REGION_MAX))));
      end
    end

    wait_until_drained();
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
